// ===== hw/rtl/cbbd_pkg.sv =====
// cbbd_pkg: shared widths, constants, types and the arctangent table for the
// cluster box block detector. No dependencies.
`default_nettype none

package cbbd_pkg;

    // coordinate width of the incoming points
    localparam int COORD_W = 16;

    // config registers
    localparam int CFG_W         = 15;
    localparam int CFG_IDX_W     = 1;
    localparam int CUBE_SIZE_RST = 400;
    localparam int SIZE_TOL_RST  = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CUBE_SIZE = 1'b0,
        REG_SIZE_TOL  = 1'b1
    } cfg_reg_t;

    // compare width for sides against size/tol, and width for centre math
    localparam int CMP_W = ((COORD_W > CFG_W) ? COORD_W : CFG_W) + 2;
    localparam int EXT_W = ((COORD_W > 16) ? COORD_W : 16) + 3;

    // diagonal test: side - tol must stay below this to be squared
    localparam int DIAG_LIMIT = 46341;
    localparam int SQ_W       = 16;
    localparam int PROD_W     = 2 * SQ_W;
    localparam int SIZE_SQ_W  = 2 * CFG_W;

    // CORDIC datapath
    localparam int CORDIC_W     = ((COORD_W > 16) ? COORD_W : 16) + 21;
    localparam int ANGLE_W      = 17;
    localparam int CORDIC_STEPS = 14;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int GAIN_Q14     = 9949;
    localparam int YAW_MAX      = 25736;
    localparam int Q14_ONE      = 16384;

    // result fields
    localparam int CX_W  = 16;
    localparam int CZ_W  = 17;
    localparam int YAW_W = 15;
    localparam int Q_W   = 16;

    localparam int IN_TDATA_W  = ((3 * COORD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * CX_W + CZ_W + YAW_W + 2 * Q_W + 7) / 8) * 8;

    typedef struct packed {
        logic load;       // load x/y/z init and start iterating
        logic vectoring;  // 1: drive y to zero, 0: rotate by z
    } cordic_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_CHKX,
        ST_CHKY,
        ST_VEC,
        ST_ROT,
        ST_OUT
    } seq_state_t;

    // atan(2^-i) in Q2.14
    function automatic logic signed [ANGLE_W-1:0] atan_q14(input logic [STEP_W-1:0] idx);
        logic signed [ANGLE_W-1:0] a;
        case (idx)
            4'd0:    a = ANGLE_W'(12868);
            4'd1:    a = ANGLE_W'(7596);
            4'd2:    a = ANGLE_W'(4014);
            4'd3:    a = ANGLE_W'(2037);
            4'd4:    a = ANGLE_W'(1023);
            4'd5:    a = ANGLE_W'(512);
            4'd6:    a = ANGLE_W'(256);
            4'd7:    a = ANGLE_W'(128);
            4'd8:    a = ANGLE_W'(64);
            4'd9:    a = ANGLE_W'(32);
            4'd10:   a = ANGLE_W'(16);
            4'd11:   a = ANGLE_W'(8);
            4'd12:   a = ANGLE_W'(4);
            4'd13:   a = ANGLE_W'(2);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cbbd_box_track.sv =====
// cbbd_box_track: running min/max of x, y, z over one cluster, seeded by the
// first point. Depends on cbbd_pkg.
`default_nettype none

module cbbd_box_track (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                upd,
    input  wire logic                                last,
    input  wire logic signed [cbbd_pkg::COORD_W-1:0] pt_x,
    input  wire logic signed [cbbd_pkg::COORD_W-1:0] pt_y,
    input  wire logic signed [cbbd_pkg::COORD_W-1:0] pt_z,
    output logic signed [cbbd_pkg::COORD_W-1:0]      min_x,
    output logic signed [cbbd_pkg::COORD_W-1:0]      max_x,
    output logic signed [cbbd_pkg::COORD_W-1:0]      min_y,
    output logic signed [cbbd_pkg::COORD_W-1:0]      max_y,
    output logic signed [cbbd_pkg::COORD_W-1:0]      min_z,
    output logic signed [cbbd_pkg::COORD_W-1:0]      max_z,
    output logic [cbbd_pkg::COORD_W-1:0]             side_x,
    output logic [cbbd_pkg::COORD_W-1:0]             side_y,
    output logic [cbbd_pkg::COORD_W-1:0]             side_z
);

    localparam int W = cbbd_pkg::COORD_W;

    logic signed [W-1:0] pt       [3];
    logic signed [W-1:0] min_reg  [3];
    logic signed [W-1:0] max_reg  [3];
    logic signed [W-1:0] min_next [3];
    logic signed [W-1:0] max_next [3];
    logic signed [W:0]   diff     [3];
    logic                first_reg;
    logic                first_next;

    assign pt[0] = pt_x;
    assign pt[1] = pt_y;
    assign pt[2] = pt_z;

    always_comb begin
        first_next = first_reg;
        if (upd) begin
            first_next = last;
        end
        for (int i = 0; i < 3; i++) begin
            min_next[i] = min_reg[i];
            max_next[i] = max_reg[i];
            if (upd) begin
                if (first_reg || (pt[i] < min_reg[i])) begin
                    min_next[i] = pt[i];
                end
                if (first_reg || (pt[i] > max_reg[i])) begin
                    max_next[i] = pt[i];
                end
            end
            // max >= min, so the difference fits W unsigned bits
            diff[i] = (W+1)'(max_reg[i]) - (W+1)'(min_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            for (int i = 0; i < 3; i++) begin
                min_reg[i] <= '0;
                max_reg[i] <= '0;
            end
        end else begin
            first_reg <= first_next;
            for (int i = 0; i < 3; i++) begin
                min_reg[i] <= min_next[i];
                max_reg[i] <= max_next[i];
            end
        end
    end

    assign min_x  = min_reg[0];
    assign max_x  = max_reg[0];
    assign min_y  = min_reg[1];
    assign max_y  = max_reg[1];
    assign min_z  = min_reg[2];
    assign max_z  = max_reg[2];
    assign side_x = diff[0][W-1:0];
    assign side_y = diff[1][W-1:0];
    assign side_z = diff[2][W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/cbbd_cordic_unit.sv =====
// cbbd_cordic_unit: one CORDIC micro-rotation per cycle, iterated 14 times,
// in vectoring or rotation mode. Depends on cbbd_pkg.
`default_nettype none

module cbbd_cordic_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire cbbd_pkg::cordic_ctl_t                ctl,
    input  wire logic signed [cbbd_pkg::CORDIC_W-1:0] x_init,
    input  wire logic signed [cbbd_pkg::CORDIC_W-1:0] y_init,
    input  wire logic signed [cbbd_pkg::ANGLE_W-1:0]  z_init,
    output logic                                      busy,
    output logic signed [cbbd_pkg::CORDIC_W-1:0]      x_out,
    output logic signed [cbbd_pkg::CORDIC_W-1:0]      y_out,
    output logic signed [cbbd_pkg::ANGLE_W-1:0]       z_out
);

    localparam int DW = cbbd_pkg::CORDIC_W;
    localparam int AW = cbbd_pkg::ANGLE_W;
    localparam int SW = cbbd_pkg::STEP_W;

    logic signed [DW-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [AW-1:0] z_reg, z_next, a;
    logic [SW-1:0]        iter_reg, iter_next;
    logic                 run_reg, run_next;
    logic                 vec_reg, vec_next;
    logic                 plus;

    always_comb begin
        xs   = x_reg >>> iter_reg;
        ys   = y_reg >>> iter_reg;
        a    = cbbd_pkg::atan_q14(iter_reg);
        // both modes share the same direction rule once the sign test is chosen
        plus = vec_reg ? (y_reg > 0) : z_reg[AW-1];

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        run_next  = run_reg;
        vec_next  = vec_reg;

        if (ctl.load) begin
            x_next    = x_init;
            y_next    = y_init;
            z_next    = z_init;
            iter_next = '0;
            run_next  = 1'b1;
            vec_next  = ctl.vectoring;
        end else if (run_reg) begin
            if (plus) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + a;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - a;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == SW'(cbbd_pkg::CORDIC_STEPS - 1)) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            iter_reg <= '0;
        end else begin
            run_reg  <= run_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        vec_reg <= vec_next;
    end

    assign busy  = run_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cluster_box_block_detector_unit.sv =====
// cluster_box_block_detector_unit: top level. Box tracking, size checks with a
// shared squarer, yaw and quaternion through one shared CORDIC unit.
// Depends on cbbd_pkg, cbbd_box_track, cbbd_cordic_unit.
`default_nettype none

// Channel   | Dir | Handshake                     | Payload
// ----------+-----+-------------------------------+----------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: point_x, point_y, point_z
//           |     |                               | tlast: last_point
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: center_x, center_y, center_z,
//           |     |                               |        yaw_angle, quat_z, quat_w
// cfg       | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// Flow: a point without tlast leaves the sequencer in idle. A tlast beat
// starts the size checks in SQR, CHKX and CHKY (squarer shared over size, x
// side, y side). A passing box then makes two CORDIC passes of 14 iterations
// each, VEC (vectoring for yaw) and ROT (rotation for the quaternion), each
// waiting until the unit is done, then OUT loads the output register; with yaw
// forced to zero CHKY goes to OUT, a failing box to idle (no beat out).
// Reset: synchronous, active low; box cleared, next point seeds it, registers
// back to cube_size 400 and size_tolerance 100.
// Stalls: s_axis_tready is high only in idle. A finished beat waits in the
// output register; new points keep flowing until the next cluster end
// completes its math and finds that register still full.
module cluster_box_block_detector_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // slave stream: [15:0] point_x, [31:16] point_y, [47:32] point_z
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [cbbd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  wire logic                                 s_axis_tlast,
    // master stream: [15:0] center_x, [31:16] center_y, [48:32] center_z,
    // [63:49] yaw_angle, [79:64] quat_z, [95:80] quat_w
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [cbbd_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // config writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [cbbd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cbbd_pkg::CFG_W-1:0]           cfg_data
);

    localparam int CW   = cbbd_pkg::COORD_W;
    localparam int MW   = cbbd_pkg::CMP_W;
    localparam int EW   = cbbd_pkg::EXT_W;
    localparam int DW   = cbbd_pkg::CORDIC_W;
    localparam int AW   = cbbd_pkg::ANGLE_W;
    localparam int YW   = cbbd_pkg::YAW_W;
    localparam int QW   = cbbd_pkg::Q_W;
    localparam int SQW  = cbbd_pkg::SQ_W;
    localparam int PW   = cbbd_pkg::PROD_W;
    localparam int SSW  = cbbd_pkg::SIZE_SQ_W;
    localparam int FW   = cbbd_pkg::CFG_W;

    localparam logic signed [EW-1:0] CX_MAX = EW'((1 << (cbbd_pkg::CX_W - 1)) - 1);
    localparam logic signed [EW-1:0] CX_MIN = -EW'(1 << (cbbd_pkg::CX_W - 1));
    localparam logic signed [EW-1:0] CZ_MAX = EW'((1 << (cbbd_pkg::CZ_W - 1)) - 1);
    localparam logic signed [EW-1:0] CZ_MIN = -EW'(1 << (cbbd_pkg::CZ_W - 1));
    localparam logic signed [DW-1:0] Q_MAX  = DW'(cbbd_pkg::Q14_ONE);
    localparam logic signed [DW-1:0] Q_MIN  = -DW'(cbbd_pkg::Q14_ONE);
    localparam logic signed [DW-1:0] Q_HALF = DW'(128);
    localparam logic signed [AW-1:0] YAW_HI = AW'(cbbd_pkg::YAW_MAX);

    function automatic logic signed [EW-1:0] clamp_ext(
        input logic signed [EW-1:0] v,
        input logic signed [EW-1:0] lo,
        input logic signed [EW-1:0] hi
    );
        logic signed [EW-1:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // ---------------- config registers ----------------
    logic [FW-1:0] cube_size_reg, size_tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cube_size_reg <= FW'(cbbd_pkg::CUBE_SIZE_RST);
            size_tol_reg  <= FW'(cbbd_pkg::SIZE_TOL_RST);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cbbd_pkg::cfg_reg_t'(cfg_index))
                cbbd_pkg::REG_CUBE_SIZE: cube_size_reg <= cfg_data;
                cbbd_pkg::REG_SIZE_TOL:  size_tol_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- box tracker ----------------
    logic                 s_accept;
    logic signed [CW-1:0] min_x, max_x, min_y, max_y, min_z, max_z;
    logic [CW-1:0]        side_x, side_y, side_z;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    cbbd_box_track u_box (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (s_accept),
        .last    (s_axis_tlast),
        .pt_x    (signed'(s_axis_tdata[CW-1:0])),
        .pt_y    (signed'(s_axis_tdata[2*CW-1:CW])),
        .pt_z    (signed'(s_axis_tdata[3*CW-1:2*CW])),
        .min_x   (min_x),
        .max_x   (max_x),
        .min_y   (min_y),
        .max_y   (max_y),
        .min_z   (min_z),
        .max_z   (max_z),
        .side_x  (side_x),
        .side_y  (side_y),
        .side_z  (side_z)
    );

    // ---------------- sequencer ----------------
    cbbd_pkg::seq_state_t state_reg, state_next;
    logic                 cordic_busy;
    logic                 out_load;
    logic                 pass;
    logic                 yaw_en;
    logic                 m_valid_reg, m_valid_next;
    cbbd_pkg::cordic_ctl_t cordic_ctl;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cbbd_pkg::ST_IDLE: begin
                if (s_accept && s_axis_tlast) begin
                    state_next = cbbd_pkg::ST_SQR;
                end
            end
            cbbd_pkg::ST_SQR:  state_next = cbbd_pkg::ST_CHKX;
            cbbd_pkg::ST_CHKX: state_next = cbbd_pkg::ST_CHKY;
            cbbd_pkg::ST_CHKY: begin
                if (!pass) begin
                    state_next = cbbd_pkg::ST_IDLE;
                end else if (yaw_en) begin
                    state_next = cbbd_pkg::ST_VEC;
                end else begin
                    state_next = cbbd_pkg::ST_OUT;
                end
            end
            cbbd_pkg::ST_VEC: begin
                if (!cordic_busy) begin
                    state_next = cbbd_pkg::ST_ROT;
                end
            end
            cbbd_pkg::ST_ROT: begin
                if (!cordic_busy) begin
                    state_next = cbbd_pkg::ST_OUT;
                end
            end
            cbbd_pkg::ST_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = cbbd_pkg::ST_IDLE;
                end
            end
            default: state_next = cbbd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready        = 1'b0;
        cordic_ctl.load      = 1'b0;
        cordic_ctl.vectoring = 1'b0;
        out_load             = 1'b0;
        unique case (state_reg)
            cbbd_pkg::ST_IDLE: s_axis_tready = 1'b1;
            cbbd_pkg::ST_CHKY: begin
                cordic_ctl.load      = pass && yaw_en;
                cordic_ctl.vectoring = 1'b1;
            end
            cbbd_pkg::ST_VEC:  cordic_ctl.load = !cordic_busy;
            cbbd_pkg::ST_OUT:  out_load = !m_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbbd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- size checks ----------------
    // One squarer: size^2 first, then (side - tol)^2 for x, then for y.
    logic signed [MW-1:0] size_e, tol_e, chk_e, zs_e, ys_e, d;
    logic [CW-1:0]        chk_side;
    logic [SQW-1:0]       mul_a;
    logic [PW-1:0]        prod;
    logic [SSW-1:0]       size_sq_reg;
    logic                 ok_reg;
    logic                 lo_ok, diag_ok, side_ok, z_ok;

    always_comb begin
        size_e   = MW'(cube_size_reg);
        tol_e    = MW'(size_tol_reg);
        chk_side = (state_reg == cbbd_pkg::ST_CHKY) ? side_y : side_x;
        chk_e    = MW'(chk_side);
        zs_e     = MW'(side_z);
        ys_e     = MW'(side_y);
        d        = chk_e - tol_e;
        mul_a    = (state_reg == cbbd_pkg::ST_SQR) ? SQW'(cube_size_reg) : d[SQW-1:0];
        prod     = PW'(mul_a) * PW'(mul_a);
        lo_ok    = (chk_e + tol_e) > size_e;
        // side < size*sqrt(2) + tol, exact through squares
        diag_ok  = d[MW-1] ||
                   ((d < MW'(cbbd_pkg::DIAG_LIMIT)) && (prod < {1'b0, size_sq_reg, 1'b0}));
        side_ok  = lo_ok && diag_ok;
        z_ok     = (zs_e > tol_e) && (zs_e < (size_e + tol_e));
        pass     = ok_reg && side_ok && z_ok;
        yaw_en   = (ys_e >= size_e) && (cube_size_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == cbbd_pkg::ST_SQR) begin
            size_sq_reg <= prod[SSW-1:0];
        end
        if (state_reg == cbbd_pkg::ST_CHKX) begin
            ok_reg <= side_ok;
        end
    end

    // ---------------- CORDIC ----------------
    logic signed [DW-1:0] x_init, y_init, x_out, y_out;
    logic signed [AW-1:0] z_init, z_out;
    logic [CW:0]          sum_xy;
    logic [YW-1:0]        yaw_clamped;
    logic [YW:0]          yaw_inc;
    logic signed [DW-1:0] qw_s, qz_s;
    logic [QW-1:0]        qw_c, qz_c;

    always_comb begin
        sum_xy = (CW+1)'(side_x) + (CW+1)'(side_y);
        if (z_out[AW-1]) begin
            yaw_clamped = '0;
        end else if (z_out > YAW_HI) begin
            yaw_clamped = YW'(cbbd_pkg::YAW_MAX);
        end else begin
            yaw_clamped = z_out[YW-1:0];
        end
        yaw_inc = (YW+1)'(yaw_clamped) + 1'b1;
        if (state_reg == cbbd_pkg::ST_CHKY) begin
            // vector ((xs+ys)*2^16, 2*size*2^16)
            x_init = DW'({sum_xy, 16'b0});
            y_init = DW'({cube_size_reg, 17'b0});
            z_init = '0;
        end else begin
            // rotate the gain-corrected unit vector by half the yaw
            x_init = DW'(cbbd_pkg::GAIN_Q14 * 256);
            y_init = '0;
            z_init = AW'(yaw_inc[YW:1]);
        end
        qw_s = (x_out + Q_HALF) >>> 8;
        qz_s = (y_out + Q_HALF) >>> 8;
        if (qw_s > Q_MAX) begin
            qw_c = QW'(cbbd_pkg::Q14_ONE);
        end else if (qw_s < Q_MIN) begin
            qw_c = QW'(-cbbd_pkg::Q14_ONE);
        end else begin
            qw_c = qw_s[QW-1:0];
        end
        if (qz_s > Q_MAX) begin
            qz_c = QW'(cbbd_pkg::Q14_ONE);
        end else if (qz_s < Q_MIN) begin
            qz_c = QW'(-cbbd_pkg::Q14_ONE);
        end else begin
            qz_c = qz_s[QW-1:0];
        end
    end

    cbbd_cordic_unit u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cordic_ctl),
        .x_init  (x_init),
        .y_init  (y_init),
        .z_init  (z_init),
        .busy    (cordic_busy),
        .x_out   (x_out),
        .y_out   (y_out),
        .z_out   (z_out)
    );

    // yaw and quaternion holding registers
    logic [YW-1:0] yaw_reg;
    logic [QW-1:0] qz_reg, qw_reg;

    always_ff @(posedge aclk) begin
        if ((state_reg == cbbd_pkg::ST_CHKY) && pass && !yaw_en) begin
            // y side shorter than the cube: yaw forced to zero
            yaw_reg <= '0;
            qz_reg  <= '0;
            qw_reg  <= QW'(cbbd_pkg::Q14_ONE);
        end else if ((state_reg == cbbd_pkg::ST_VEC) && !cordic_busy) begin
            yaw_reg <= yaw_clamped;
        end else if ((state_reg == cbbd_pkg::ST_ROT) && !cordic_busy) begin
            qz_reg <= qz_c;
            qw_reg <= qw_c;
        end
    end

    // ---------------- centre and output register ----------------
    logic signed [EW-1:0] sum_cx, sum_cy, cz_raw, size_x;
    logic signed [EW-1:0] cx_c, cy_c, cz_c;
    logic [cbbd_pkg::OUT_TDATA_W-1:0] m_data_reg;

    always_comb begin
        sum_cx = EW'(min_x) + EW'(max_x);
        sum_cy = EW'(min_y) + EW'(max_y);
        size_x = EW'(cube_size_reg);
        cz_raw = (EW'(max_z) <<< 1) - size_x;
        cx_c   = clamp_ext(sum_cx >>> 1, CX_MIN, CX_MAX);
        cy_c   = clamp_ext(sum_cy >>> 1, CX_MIN, CX_MAX);
        cz_c   = clamp_ext(cz_raw >>> 1, CZ_MIN, CZ_MAX);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= cbbd_pkg::OUT_TDATA_W'({qw_reg, qz_reg, yaw_reg,
                                                  cz_c[cbbd_pkg::CZ_W-1:0],
                                                  cy_c[cbbd_pkg::CX_W-1:0],
                                                  cx_c[cbbd_pkg::CX_W-1:0]});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for cluster_box_block_detector_unit. Streams point
// clusters, predicts box results bit-exactly and checks every output beat.
// Depends on cbbd_pkg and the detector RTL.

module tb;

    localparam int  DRAIN_CYCLES = 50;   // longer than the worst cluster-end latency
    localparam int  LONG_HOLD    = 400;
    localparam int  IDLE_LIMIT   = 5000;
    localparam int  PHASES       = 9;

    // one point as it goes on the bus; c[0] = x sits in the low bits
    typedef struct packed {
        logic             last;
        logic [2:0][15:0] c;
    } point_t;

    // laid out exactly like m_axis_tdata, last field lowest
    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qz;
        logic        [14:0] yaw;
        logic signed [16:0] cz;
        logic signed [15:0] cy;
        logic signed [15:0] cx;
    } box_result_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [cbbd_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic                               s_axis_tlast = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [cbbd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    cbbd_pkg::cfg_reg_t                 cfg_index = cbbd_pkg::REG_CUBE_SIZE;
    logic [cbbd_pkg::CFG_W-1:0]         cfg_data = '0;

    cluster_box_block_detector_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    point_t      points_pending[$];     // beats waiting for the driver
    box_result_t box_results_due[$];    // predicted results, oldest first
    int          error_count = 0;
    int          points_made = 0;
    bit          s_quiet = 1'b0;        // no gaps on the input side
    bit          m_quiet = 1'b0;        // no stalls on the output side
    int          long_holds_wanted = 0;
    int          long_holds_done = 0;
    bit          in_beat_taken = 1'b0;  // input beat accepted at the last edge
    int          send_gap = 0;
    int          recv_hold = 0;
    int          idle_cycles = 0;
    point_t      next_pt;

    // predictor copy of the block: config plus running box
    longint      cube_sz, size_tol;
    longint      lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    bit          seed_next;
    longint      arctan_step [14] = '{12868, 7596, 4014, 2037, 1023, 512, 256,
                                      128, 64, 32, 16, 8, 4, 2};

    function automatic longint clampv(input longint v, input longint lo,
                                      input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // exact side < size*sqrt(2) + tol, squared to stay in integers
    function automatic bit under_diag(input longint side);
        longint d;
        d = side - size_tol;
        if (d < 0)
            return 1'b1;
        if (d >= 46341)
            return 1'b0;
        return d * d < 2 * cube_sz * cube_sz;
    endfunction

    // fold one accepted point into the box; on the cluster end, decide
    // pass/fail and, for a pass, queue the expected result
    task automatic absorb_point(input longint px, input longint py,
                                input longint pz, input bit last);
        longint      xs, ys, zs, yaw, vx, vy, rz, sx, sy;
        box_result_t r;
        bit          ok;
        if (seed_next) begin
            lo_x = px; hi_x = px;
            lo_y = py; hi_y = py;
            lo_z = pz; hi_z = pz;
        end else begin
            if (px < lo_x) lo_x = px;
            if (px > hi_x) hi_x = px;
            if (py < lo_y) lo_y = py;
            if (py > hi_y) hi_y = py;
            if (pz < lo_z) lo_z = pz;
            if (pz > hi_z) hi_z = pz;
        end
        seed_next = last;
        if (!last)
            return;
        xs = hi_x - lo_x;
        ys = hi_y - lo_y;
        zs = hi_z - lo_z;
        ok = xs > cube_sz - size_tol && under_diag(xs) &&
             ys > cube_sz - size_tol && under_diag(ys) &&
             zs > size_tol && zs < cube_sz + size_tol;
        if (!ok)
            return;
        r.yaw = '0;
        r.qz  = '0;
        r.qw  = 16'(cbbd_pkg::Q14_ONE);
        if (ys >= cube_sz && cube_sz > 0) begin
            // vectoring: angle of (xs + ys, 2*size), Q2.14
            vx  = (xs + ys) <<< 16;
            vy  = (2 * cube_sz) <<< 16;
            yaw = 0;
            for (int i = 0; i < 14; i++) begin
                sx = vx >>> i;
                sy = vy >>> i;
                if (vy > 0) begin
                    vx += sy; vy -= sx; yaw += arctan_step[i];
                end else begin
                    vx -= sy; vy += sx; yaw -= arctan_step[i];
                end
            end
            yaw = clampv(yaw, 0, cbbd_pkg::YAW_MAX);
            // rotation by half the yaw from a gain-compensated unit vector
            rz = (yaw + 1) >>> 1;
            vx = longint'(cbbd_pkg::GAIN_Q14) * 256;
            vy = 0;
            for (int i = 0; i < 14; i++) begin
                sx = vx >>> i;
                sy = vy >>> i;
                if (rz >= 0) begin
                    vx -= sy; vy += sx; rz -= arctan_step[i];
                end else begin
                    vx += sy; vy -= sx; rz += arctan_step[i];
                end
            end
            r.yaw = 15'(yaw);
            r.qw  = 16'(clampv((vx + 128) >>> 8, -cbbd_pkg::Q14_ONE, cbbd_pkg::Q14_ONE));
            r.qz  = 16'(clampv((vy + 128) >>> 8, -cbbd_pkg::Q14_ONE, cbbd_pkg::Q14_ONE));
        end
        // floor halving: >>> on signed longint rounds toward minus infinity
        r.cx = 16'(clampv((lo_x + hi_x) >>> 1, -32768, 32767));
        r.cy = 16'(clampv((lo_y + hi_y) >>> 1, -32768, 32767));
        r.cz = 17'(clampv((2 * hi_z - cube_sz) >>> 1, -65536, 65535));
        box_results_due.insert(box_results_due.size(), r);
    endtask

    task automatic check_field(input string fname, input longint want_v,
                               input longint got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", fname, want_v, got_v);
            error_count++;
        end
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pause_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 1;
        if (r < 90)
            return $urandom_range(4, 2);
        if (r < 98)
            return $urandom_range(12, 5);
        return $urandom_range(60, 20);
    endfunction

    // ------------------------------------------------------------------
    // Monitor and predictor: everything sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            cube_sz   = cbbd_pkg::CUBE_SIZE_RST;
            size_tol  = cbbd_pkg::SIZE_TOL_RST;
            lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0; lo_z = 0; hi_z = 0;
            seed_next = 1'b1;
            in_beat_taken <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    cbbd_pkg::REG_CUBE_SIZE: cube_sz  = cfg_data;
                    cbbd_pkg::REG_SIZE_TOL:  size_tol = cfg_data;
                    default: ;
                endcase
            end
            // result beat: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                box_result_t got, want;
                got = m_axis_tdata;
                if ($isunknown(m_axis_tdata)) begin
                    $error("m_axis_tdata has unknown bits: %h", m_axis_tdata);
                    error_count++;
                end
                if (box_results_due.size() == 0) begin
                    $error("unexpected result beat: %h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = box_results_due.pop_front();
                    check_field("center_x",  want.cx,  got.cx);
                    check_field("center_y",  want.cy,  got.cy);
                    check_field("center_z",  want.cz,  got.cz);
                    check_field("yaw_angle", want.yaw, got.yaw);
                    check_field("quat_z",    want.qz,  got.qz);
                    check_field("quat_w",    want.qw,  got.qw);
                end
            end
            // point beat: advance the predicted box
            if (s_axis_tvalid && s_axis_tready)
                absorb_point($signed(s_axis_tdata[15:0]), $signed(s_axis_tdata[31:16]),
                             $signed(s_axis_tdata[47:32]), s_axis_tlast);
            in_beat_taken <= s_axis_tvalid && s_axis_tready;
        end
    end

    // ------------------------------------------------------------------
    // Point driver: holds a beat until taken, random gaps between beats
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_beat_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (points_pending.size() != 0) begin
                next_pt = points_pending.pop_front();
                s_axis_tdata  <= next_pt.c;
                s_axis_tlast  <= next_pt.last;
                s_axis_tvalid <= 1'b1;
                send_gap = (s_quiet || $urandom_range(99, 0) < 60) ? 0 : pause_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (long_holds_done != long_holds_wanted) begin
                long_holds_done++;
                recv_hold = LONG_HOLD;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end else if (!m_quiet && $urandom_range(99, 0) < 15) begin
                recv_hold = pause_len() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any beat on any channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_point(input int x, input int y, input int z, input bit last);
        point_t p;
        p.c[0] = 16'(x);
        p.c[1] = 16'(y);
        p.c[2] = 16'(z);
        p.last = last;
        points_pending.insert(points_pending.size(), p);
        points_made++;
    endtask

    // one cluster: mostly a box whose sides straddle the acceptance window,
    // otherwise random noise or a lone point
    task automatic queue_cluster(input longint sz, input longint tl);
        point_t pts[$];
        point_t p;
        longint span[3];
        longint base[3];
        longint lo, hi;
        int     kind, n, a, b;
        kind = $urandom_range(99, 0);
        if (kind < 22) begin
            n = (kind < 10) ? 1 : $urandom_range(8, 1);
            for (int i = 0; i < n; i++) begin
                p.c  = {16'($urandom), 16'($urandom), 16'($urandom)};
                p.last = 1'b0;
                pts.insert(pts.size(), p);
            end
        end else begin
            n = (kind < 27) ? $urandom_range(60, 30) : $urandom_range(10, 2);
            for (int k = 0; k < 3; k++) begin
                if (k < 2) begin
                    lo = sz - tl - 3;
                    hi = (sz * 14143) / 10000 + tl + 3;
                end else begin
                    lo = tl - 3;
                    hi = sz + tl + 3;
                end
                lo = clampv(lo, 0, 65535);
                hi = clampv(hi, 0, 65535);
                if ($urandom_range(99, 0) < 85)
                    span[k] = $urandom_range(int'(hi), int'(lo));
                else
                    span[k] = $urandom_range(65535, 0);
                base[k] = longint'($urandom_range(65535 - int'(span[k]), 0)) - 32768;
            end
            for (int i = 0; i < n; i++) begin
                for (int k = 0; k < 3; k++)
                    p.c[k] = 16'(base[k] + longint'($urandom_range(int'(span[k]), 0)));
                p.last = 1'b0;
                pts.insert(pts.size(), p);
            end
            // pin the extremes of each axis on two distinct random points
            for (int k = 0; k < 3; k++) begin
                a = $urandom_range(n - 1, 0);
                b = (a + 1 + $urandom_range(n - 2, 0)) % n;
                pts[a].c[k] = 16'(base[k]);
                pts[b].c[k] = 16'(base[k] + span[k]);
            end
        end
        pts[n - 1].last = 1'b1;
        foreach (pts[i])
            points_pending.insert(points_pending.size(), pts[i]);
        points_made += n;
    endtask

    task automatic write_reg(input cbbd_pkg::cfg_reg_t idx, input longint val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[cbbd_pkg::CFG_W-1:0];
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // sender stops until every result is in, then lets a failing cluster
    // end finish its checks before anything else happens
    task automatic drain();
        while (points_pending.size() != 0 || s_axis_tvalid || box_results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        // cube size / tolerance per phase; -1 picks a random setting
        int     ph_size [PHASES];
        int     ph_tol  [PHASES];
        longint sz, tl;
        int     budget;

        ph_size = '{0, 32767, 32767, 0, 1, -1, -1, 400, -1};
        ph_tol  = '{0, 32767, 0, 32767, 0, -1, -1, 100, -1};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, reset settings: size 400, tolerance 100
        push_point(32767, -32768, 0, 1'b1);             // lone point, fails
        push_point(-32768, -32768, -32768, 1'b0);       // full-range box, fails
        push_point(32767, 32767, 32767, 1'b1);
        push_point(0, 0, 0, 1'b0);                      // passes, real yaw
        push_point(250, 100, 50, 1'b0);
        push_point(500, 500, 200, 1'b1);
        push_point(-1001, -20, -7, 1'b0);               // y side under size: yaw 0
        push_point(-551, 330, 193, 1'b1);
        push_point(-3, -3, -3, 1'b0);                   // odd sums, floor centre
        push_point(498, 458, 297, 1'b1);
        push_point(0, 0, 0, 1'b0);                      // z side equals tol, fails
        push_point(500, 500, 100, 1'b1);
        push_point(0, 0, 0, 1'b0);                      // x just under diagonal
        push_point(665, 450, 200, 1'b1);
        push_point(0, 0, 0, 1'b0);                      // x just over diagonal
        push_point(666, 450, 200, 1'b1);
        push_point(0, 0, 0, 1'b0);                      // x one above size - tol
        push_point(301, 401, 200, 1'b1);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph_size[ph] < 0) begin
                sz = $urandom_range(3000, 50);
                tl = $urandom_range(int'(sz / 3) + 5, 0);
            end else begin
                sz = ph_size[ph];
                tl = ph_tol[ph];
            end
            write_reg(cbbd_pkg::REG_CUBE_SIZE, sz);
            write_reg(cbbd_pkg::REG_SIZE_TOL, tl);
            s_quiet = (ph == 2 || ph == 6);
            m_quiet = (ph == 2 || ph == 6);
            // backpressure test: receiver goes away while points keep coming
            if (ph == 7)
                long_holds_wanted++;
            // size zero can never pass, so keep that phase short
            budget = points_made + ((sz == 0) ? 60 : 140);
            while (points_made < budget)
                queue_cluster(sz, tl);
            drain();
        end

        if (error_count == 0 && box_results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== cluster_box_block_detector_unit.f =====
hw/rtl/cbbd_pkg.sv
hw/rtl/cbbd_box_track.sv
hw/rtl/cbbd_cordic_unit.sv
hw/rtl/cluster_box_block_detector_unit.sv
sim/tb.sv
